/* rtl/stlp_pkg.sv */
// ----------------------------------------------------------------------------
// stlp_pkg
// Types, constants and lookup functions for the SNTP time line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package stlp_pkg;

  localparam int PrefixLen = 13;
  localparam int PosW      = $clog2(PrefixLen + 1);

  // Parse phases; number phases come in start/body pairs, day first.
  typedef enum logic [3:0] {
    PH_SEARCH   = 4'd0,
    PH_WD       = 4'd1,
    PH_MO       = 4'd2,
    PH_D_START  = 4'd3,
    PH_D_BODY   = 4'd4,
    PH_H_START  = 4'd5,
    PH_H_BODY   = 4'd6,
    PH_MI_START = 4'd7,
    PH_MI_BODY  = 4'd8,
    PH_S_START  = 4'd9,
    PH_S_BODY   = 4'd10,
    PH_Y_START  = 4'd11,
    PH_Y_BODY   = 4'd12,
    PH_DONE     = 4'd13,
    PH_FAIL     = 4'd14
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_PREFIX = 2'd1,
    ST_MISMATCH  = 2'd2
  } status_t;

  localparam logic [7:0] PREFIX_TEXT [PrefixLen] = '{
    8'h2B, 8'h43, 8'h49, 8'h50, 8'h53, 8'h4E, 8'h54,
    8'h50, 8'h54, 8'h49, 8'h4D, 8'h45, 8'h3A
  };

  localparam logic [23:0] DAY_NAMES [7] = '{
    24'h4D6F6E, 24'h547565, 24'h576564, 24'h546875,
    24'h467269, 24'h536174, 24'h53756E
  };

  localparam logic [23:0] MON_NAMES [12] = '{
    24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072,
    24'h4D6179, 24'h4A756E, 24'h4A756C, 24'h417567,
    24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
  };

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] SatLimit = 32'd429496729;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_num_start(input phase_t p);
    return (p == PH_D_START) || (p == PH_H_START) || (p == PH_MI_START) ||
           (p == PH_S_START) || (p == PH_Y_START);
  endfunction

  function automatic logic is_num_body(input phase_t p);
    return (p == PH_D_BODY) || (p == PH_H_BODY) || (p == PH_MI_BODY) ||
           (p == PH_S_BODY) || (p == PH_Y_BODY);
  endfunction

  // Unknown weekday reads as Monday.
  function automatic logic [2:0] weekday_code(input logic [23:0] w);
    logic [2:0] code;
    code = 3'd1;
    for (int i = 6; i >= 0; i--) begin
      if (w == DAY_NAMES[i]) begin
        code = 3'(i + 1);
      end
    end
    return code;
  endfunction

  // Unknown month reads as zero.
  function automatic logic [3:0] month_code(input logic [23:0] w);
    logic [3:0] code;
    code = 4'd0;
    for (int i = 11; i >= 0; i--) begin
      if (w == MON_NAMES[i]) begin
        code = 4'(i + 1);
      end
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/sntp_time_line_parser.sv */
// ----------------------------------------------------------------------------
// sntp_time_line_parser
// Streams a modem response and extracts the SNTP date and time fields.
// ----------------------------------------------------------------------------
// Takes one byte per cycle. Every byte is handled in the cycle it is
// accepted, by the parse state registers; the item flagged last_byte
// produces one result in the output register on the next cycle, and the
// parser is back in its reset state for the next response right away.
// Ordinary bytes keep flowing while a result waits; only a last byte is
// held off (in_stall) while the previous result has not yet been taken.
// The first "+CIPSNTPTIME:" is searched for, then the weekday word, the
// month word, day, hour:minute:second and year are read. A zero byte
// ends the text. Status 0 is ok, 1 no prefix, 2 format mismatch; on a
// failure all other result fields are zero.
`default_nettype none

module sntp_time_line_parser
  import stlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [2:0]       out_weekday,
  output logic [3:0]       out_month,
  output logic [7:0]       out_day,
  output logic [7:0]       out_hour,
  output logic [7:0]       out_minute,
  output logic [7:0]       out_second,
  output logic [15:0]      out_year
);

  // Parse state
  phase_t            phase_r, phase_nxt;
  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [23:0]       wd_chars_r, wd_chars_nxt;
  logic [23:0]       mo_chars_r, mo_chars_nxt;
  logic [1:0]        word_len_r, word_len_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic              neg_r, neg_nxt;
  logic              seen_r, seen_nxt;
  logic [7:0]        held_r [4];
  logic [7:0]        held_nxt [4];
  logic              ended_r, ended_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [2:0]        weekday_r, weekday_nxt;
  logic [3:0]        month_r, month_nxt;
  logic [7:0]        day_r, day_nxt;
  logic [7:0]        hour_r, hour_nxt;
  logic [7:0]        minute_r, minute_nxt;
  logic [7:0]        second_r, second_nxt;
  logic [15:0]       year_r, year_nxt;

  logic in_acc;
  logic last_acc;

  assign in_stall = out_valid_r & out_stall & in_last_byte;
  assign in_acc   = in_valid & ~in_stall;
  assign last_acc = in_acc & in_last_byte;

  // --------------------------------------------------------------------------
  // Next parse state
  // --------------------------------------------------------------------------
  always_comb begin
    logic [7:0]      c;
    logic [3:0]      d;
    logic            bytes_go;
    logic            redo;
    logic            start_go;
    logic [PosW-1:0] pos_inc;
    logic [3:0]      rel;
    logic [7:0]      val8;

    c        = in_data_byte;
    d        = 4'(c - CH_ZERO);
    bytes_go = in_acc & ~ended_r & (c != 8'h00);
    redo     = 1'b0;
    pos_inc  = '0;
    rel      = 4'(phase_r) - 4'(PH_D_START);
    val8     = neg_r ? (8'h00 - acc_r[7:0]) : acc_r[7:0];

    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    wd_chars_nxt = wd_chars_r;
    mo_chars_nxt = mo_chars_r;
    word_len_nxt = word_len_r;
    acc_nxt      = acc_r;
    neg_nxt      = neg_r;
    seen_nxt     = seen_r;
    held_nxt     = held_r;
    ended_nxt    = ended_r;

    if (in_acc && !ended_r && (c == 8'h00)) begin
      ended_nxt = 1'b1;
    end

    // first pass: everything but the start of a number
    if (bytes_go) begin
      unique case (phase_r)
        PH_SEARCH: begin
          if (c == PREFIX_TEXT[pos_r]) begin
            pos_inc = pos_r + 1'b1;
          end else begin
            pos_inc = (c == CH_PLUS) ? PosW'(1) : '0;
          end
          if (pos_inc == PosW'(PrefixLen)) begin
            pos_nxt      = '0;
            word_len_nxt = '0;
            phase_nxt    = PH_WD;
          end else begin
            pos_nxt = pos_inc;
          end
        end
        PH_WD, PH_MO: begin
          if (is_ws(c)) begin
            if (word_len_r != 2'd0) begin
              word_len_nxt = '0;
              phase_nxt    = phase_t'(4'(phase_r) + 4'd1);
            end
          end else begin
            if (phase_r == PH_WD) begin
              wd_chars_nxt = {wd_chars_r[15:0], c};
            end else begin
              mo_chars_nxt = {mo_chars_r[15:0], c};
            end
            if (word_len_r == 2'd2) begin
              word_len_nxt = '0;
              phase_nxt    = phase_t'(4'(phase_r) + 4'd1);
            end else begin
              word_len_nxt = word_len_r + 2'd1;
            end
          end
        end
        PH_D_START, PH_H_START, PH_MI_START, PH_S_START, PH_Y_START,
        PH_DONE, PH_FAIL: begin
        end
        PH_D_BODY, PH_H_BODY, PH_MI_BODY, PH_S_BODY, PH_Y_BODY: begin
          if (is_digit(c)) begin
            if ((acc_r > SatLimit) || ((acc_r == SatLimit) && (d > 4'd5))) begin
              acc_nxt = '1;
              neg_nxt = 1'b0;
            end else begin
              acc_nxt = (acc_r << 3) + (acc_r << 1) + 32'(d);
            end
            seen_nxt = 1'b1;
          end else if (!seen_r) begin
            phase_nxt = PH_FAIL;
          end else if (phase_r == PH_Y_BODY) begin
            // year keeps its sign; it is applied when the result is built
            phase_nxt = PH_DONE;
          end else begin
            held_nxt[rel[2:1]] = val8;
            if ((phase_r == PH_H_BODY) || (phase_r == PH_MI_BODY)) begin
              phase_nxt = (c == CH_COLON) ? phase_t'(4'(phase_r) + 4'd1) : PH_FAIL;
            end else begin
              // day and second: hand the same byte to the next number
              phase_nxt = phase_t'(4'(phase_r) + 4'd1);
              redo      = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = PH_FAIL;
        end
      endcase
    end

    // second pass: start of a number
    start_go = bytes_go & (is_num_start(phase_r) | redo);
    if (start_go && !is_ws(c)) begin
      acc_nxt  = '0;
      neg_nxt  = 1'b0;
      seen_nxt = 1'b0;
      if ((c == CH_PLUS) || (c == CH_MINUS)) begin
        neg_nxt   = (c == CH_MINUS);
        phase_nxt = phase_t'(4'(phase_nxt) + 4'd1);
      end else if (is_digit(c)) begin
        acc_nxt   = 32'(d);
        seen_nxt  = 1'b1;
        phase_nxt = phase_t'(4'(phase_nxt) + 4'd1);
      end else begin
        phase_nxt = PH_FAIL;
      end
    end

    // end of text: zero byte or last byte
    if ((in_acc && !ended_r && (c == 8'h00)) || last_acc) begin
      if ((phase_nxt == PH_Y_BODY) && seen_nxt) begin
        phase_nxt = PH_DONE;
      end else if ((phase_nxt != PH_SEARCH) && (phase_nxt != PH_DONE)) begin
        phase_nxt = PH_FAIL;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    status_nxt    = status_r;
    weekday_nxt   = weekday_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    second_nxt    = second_r;
    year_nxt      = year_r;

    if (last_acc) begin
      out_valid_nxt = 1'b1;
      weekday_nxt   = '0;
      month_nxt     = '0;
      day_nxt       = '0;
      hour_nxt      = '0;
      minute_nxt    = '0;
      second_nxt    = '0;
      year_nxt      = '0;
      if (phase_nxt == PH_SEARCH) begin
        status_nxt = ST_NO_PREFIX;
      end else if (phase_nxt != PH_DONE) begin
        status_nxt = ST_MISMATCH;
      end else begin
        status_nxt  = ST_OK;
        weekday_nxt = weekday_code(wd_chars_r);
        month_nxt   = month_code(mo_chars_r);
        day_nxt     = held_r[0];
        hour_nxt    = held_r[1];
        minute_nxt  = held_r[2];
        second_nxt  = held_r[3];
        year_nxt    = neg_nxt ? (16'h0000 - acc_nxt[15:0]) : acc_nxt[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || last_acc) begin
      phase_r    <= PH_SEARCH;
      pos_r      <= '0;
      wd_chars_r <= '0;
      mo_chars_r <= '0;
      word_len_r <= '0;
      acc_r      <= '0;
      neg_r      <= 1'b0;
      seen_r     <= 1'b0;
      ended_r    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        held_r[i] <= '0;
      end
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      wd_chars_r <= wd_chars_nxt;
      mo_chars_r <= mo_chars_nxt;
      word_len_r <= word_len_nxt;
      acc_r      <= acc_nxt;
      neg_r      <= neg_nxt;
      seen_r     <= seen_nxt;
      ended_r    <= ended_nxt;
      held_r     <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    weekday_r <= weekday_nxt;
    month_r   <= month_nxt;
    day_r     <= day_nxt;
    hour_r    <= hour_nxt;
    minute_r  <= minute_nxt;
    second_r  <= second_nxt;
    year_r    <= year_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_weekday = weekday_r;
  assign out_month   = month_r;
  assign out_day     = day_r;
  assign out_hour    = hour_r;
  assign out_minute  = minute_r;
  assign out_second  = second_r;
  assign out_year    = year_r;

endmodule

`default_nettype wire

/* sim/sntp_time_line_parser_tb.sv */
// ----------------------------------------------------------------------------
// sntp_time_line_parser_tb
// Self-checking bench for the SNTP time line parser.
// ----------------------------------------------------------------------------
// Feeds whole modem responses one byte per item. A scripted set of responses
// comes first; random ones follow: mostly well-formed time lines with random
// fields, some broken, some plain noise. A local parser follows every
// accepted byte and queues the result each response should give. Results
// from the block are compared field by field. The sender idles and the
// receiver stalls at random in two of three mixes; one long output hold.
// ----------------------------------------------------------------------------

module sntp_time_line_parser_tb;
  import stlp_pkg::phase_t, stlp_pkg::status_t;
  import stlp_pkg::PH_SEARCH, stlp_pkg::PH_WD, stlp_pkg::PH_MO;
  import stlp_pkg::PH_D_START, stlp_pkg::PH_D_BODY, stlp_pkg::PH_H_BODY;
  import stlp_pkg::PH_MI_BODY, stlp_pkg::PH_Y_BODY;
  import stlp_pkg::PH_DONE, stlp_pkg::PH_FAIL;
  import stlp_pkg::ST_OK, stlp_pkg::ST_NO_PREFIX, stlp_pkg::ST_MISMATCH;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          QUIET_LIMIT = 3000;
  localparam int          TAG_LEN     = 13;
  localparam logic [103:0] TAG_TEXT   = "+CIPSNTPTIME:";
  localparam logic [167:0] DAY_LIST   = "MonTueWedThuFriSatSun";
  localparam logic [287:0] MON_LIST   = "JanFebMarAprMayJunJulAugSepOctNovDec";
  localparam logic [31:0]  ACC_SAT_AT = 32'd429496729;

  typedef struct packed {
    status_t     status;
    logic [2:0]  weekday;
    logic [3:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [15:0] year;
  } time_fields_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         last;
    logic         typed;
    time_fields_t want;
  } text_item_t;

  typedef struct {
    string        text;
    bit           nul;
    string        tail;
    bit           typed;
    time_fields_t want;
  } script_row_t;

  localparam time_fields_t NO_TAG   = {ST_NO_PREFIX, 55'd0};
  localparam time_fields_t BAD_TEXT = {ST_MISMATCH, 55'd0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [2:0]  out_weekday;
  logic [3:0]  out_month;
  logic [7:0]  out_day;
  logic [7:0]  out_hour;
  logic [7:0]  out_minute;
  logic [7:0]  out_second;
  logic [15:0] out_year;

  text_item_t   cur = '0;
  text_item_t   byte_q [$];
  time_fields_t due_times [$];
  logic [7:0]   txt [$];

  int send_idle = 8;
  int recv_stall = 70;
  int hold_req = 0;
  int hold_left = 0;
  int quiet = 0;
  int unsigned n_queued = 0, n_taken = 0, n_resp = 0, n_results = 0;
  int unsigned n_ok = 0, n_notag = 0, n_bad = 0, errors = 0;

  // local copy of the parser state
  phase_t      ph = PH_SEARCH;
  int unsigned tag_pos = 0;
  logic [23:0] wd_word = '0;
  logic [23:0] mo_word = '0;
  int unsigned word_cnt = 0;
  logic [31:0] acc = '0;
  bit          acc_neg = 0;
  bit          saw_digit = 0;
  bit          text_over = 0;
  logic [7:0]  held [4] = '{default: 8'd0};

  script_row_t script [21] = '{
    '{"+CIPSNTPTIME:Mon Jan 01 00:00:00 1970", 1'b1, "", 1'b1,
      '{ST_OK, 3'd1, 4'd1, 8'd1, 8'd0, 8'd0, 8'd0, 16'd1970}},
    '{"+CIPSNTPTIME:Sun Dec 31 23:59:59 2099\r\nOK\r\n", 1'b0, "", 1'b1,
      '{ST_OK, 3'd7, 4'd12, 8'd31, 8'd23, 8'd59, 8'd59, 16'd2099}},
    '{"+CIPSNTPTIME:Wed Jul 255 255:255:255 65535", 1'b1, "", 1'b1,
      '{ST_OK, 3'd3, 4'd7, 8'd255, 8'd255, 8'd255, 8'd255, 16'd65535}},
    '{"+CIPSNTPTIME:Thu Feb 256 300:-1:+7 65536", 1'b1, "", 1'b1,
      '{ST_OK, 3'd4, 4'd2, 8'd0, 8'd44, 8'd255, 8'd7, 16'd0}},
    '{"+CIPSNTPTIME:Fri Mar 99999999999 1:2:3 -99999999999", 1'b1, "", 1'b1,
      '{ST_OK, 3'd5, 4'd3, 8'd255, 8'd1, 8'd2, 8'd3, 16'd65535}},
    '{"no prefix here", 1'b0, "", 1'b1, NO_TAG},
    '{"", 1'b1, "", 1'b1, NO_TAG},
    '{"\377\200\177", 1'b0, "", 1'b1, NO_TAG},
    '{"+CIPSN", 1'b1, "TPTIME:Mon Jan 1 2:3:4 5", 1'b1, NO_TAG},
    '{"+CIPSNTPTIME:Tue Apr 3 12 34:56 2024", 1'b1, "", 1'b1, BAD_TEXT},
    '{"+CIPSNTPTIME:Sat May 3 12 :34:56 2024", 1'b1, "", 1'b1, BAD_TEXT},
    '{"+CIPSNTPTIME:Sat May - 1:2:3 4", 1'b1, "", 1'b1, BAD_TEXT},
    '{"+CIPSNTPTIME:Mon Jun 5 6:7", 1'b1, "8 2020", 1'b1, BAD_TEXT},
    '{"xx+CIPSNTPTIME:", 1'b0, "", 1'b1, BAD_TEXT},
    '{"+CIPSNTPTIME:MonAug 9 1:2:3 2000", 1'b1, "", 1'b0, '0},
    '{"+CIPSNTPTIME:Monday Sep 1 2:3:4 5", 1'b1, "", 1'b0, '0},
    '{"+CIPSNTPTIME:Xyz Foo 1 2:3:4 5", 1'b0, "", 1'b0, '0},
    '{"++CIPSNTP+CIPSNTPTIME: Mo Oc 10 10:10:10 2010", 1'b1, "\001", 1'b0, '0},
    '{"+CIPSNTPTIME:Sat Nov 1 2:3:4 5 +CIPSNTPTIME:Sun Dec 9 9:9:9 9", 1'b0, "",
      1'b0, '0},
    '{"+CIPSNTPTIME:\tWed\nOct\0131\r2:3:4\0145", 1'b0, "", 1'b0, '0},
    '{"+CIPSNTPTIME:Mon Jan 1:2:3:4 5", 1'b1, "", 1'b0, '0}
  };

  sntp_time_line_parser uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_weekday  (out_weekday),
    .out_month    (out_month),
    .out_day      (out_day),
    .out_hour     (out_hour),
    .out_minute   (out_minute),
    .out_second   (out_second),
    .out_year     (out_year)
  );

  assign in_data_byte = cur.data;
  assign in_last_byte = cur.last;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- parser

  function automatic bit blank(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic bit is_dec(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic [31:0] signed_acc();
    return acc_neg ? (32'd0 - acc) : acc;
  endfunction

  function automatic void clear_parser();
    ph = PH_SEARCH;
    tag_pos = 0;
    wd_word = '0;
    mo_word = '0;
    word_cnt = 0;
    acc = '0;
    acc_neg = 0;
    saw_digit = 0;
    text_over = 0;
    for (int i = 0; i < 4; i++) held[i] = 8'd0;
  endfunction

  function automatic void take_word(logic [7:0] c, bit is_month);
    phase_t nxt;
    nxt = is_month ? PH_D_START : PH_MO;
    if (blank(c)) begin
      if (word_cnt != 0) begin
        word_cnt = 0;
        ph = nxt;
      end
      return;
    end
    if (is_month) mo_word = {mo_word[15:0], c};
    else wd_word = {wd_word[15:0], c};
    word_cnt++;
    if (word_cnt >= 3) begin
      word_cnt = 0;
      ph = nxt;
    end
  endfunction

  // Returns 1 when the byte ends a field and must be taken again by the next.
  function automatic bit take_num(logic [7:0] c);
    logic [31:0] d;
    logic [31:0] v;
    int idx;
    d = 32'(c - 8'h30);
    if ((int'(ph) % 2) == 1) begin
      if (blank(c)) return 0;
      acc = '0;
      acc_neg = 0;
      saw_digit = 0;
      if (c == "+" || c == "-") begin
        acc_neg = (c == "-");
      end else if (is_dec(c)) begin
        acc = d;
        saw_digit = 1;
      end else begin
        ph = PH_FAIL;
        return 0;
      end
      ph = phase_t'(ph + 4'd1);
      return 0;
    end
    if (is_dec(c)) begin
      if (acc > ACC_SAT_AT || (acc == ACC_SAT_AT && d > 32'd5)) begin
        acc = '1;
        acc_neg = 0;
      end else begin
        acc = acc * 32'd10 + d;
      end
      saw_digit = 1;
      return 0;
    end
    if (!saw_digit) begin
      ph = PH_FAIL;
      return 0;
    end
    v = signed_acc();
    if (ph == PH_Y_BODY) begin
      acc = v;
      acc_neg = 0;
      ph = PH_DONE;
      return 0;
    end
    idx = (int'(ph) - int'(PH_D_BODY)) / 2;
    held[idx] = v[7:0];
    if (ph == PH_H_BODY || ph == PH_MI_BODY) begin
      ph = (c == ":") ? phase_t'(ph + 4'd1) : PH_FAIL;
      return 0;
    end
    ph = phase_t'(ph + 4'd1);
    return 1;
  endfunction

  function automatic bit take_text(logic [7:0] c);
    case (ph)
      PH_SEARCH: begin
        if (c == TAG_TEXT[8 * (TAG_LEN - 1 - tag_pos) +: 8]) tag_pos++;
        else tag_pos = (c == "+") ? 1 : 0;
        if (tag_pos >= TAG_LEN) begin
          tag_pos = 0;
          word_cnt = 0;
          ph = PH_WD;
        end
      end
      PH_WD: take_word(c, 1'b0);
      PH_MO: take_word(c, 1'b1);
      PH_DONE, PH_FAIL: ;
      default: return take_num(c);
    endcase
    return 0;
  endfunction

  function automatic void end_text();
    if (ph == PH_Y_BODY && saw_digit) begin
      acc = signed_acc();
      acc_neg = 0;
      ph = PH_DONE;
    end else if (ph != PH_SEARCH && ph != PH_DONE) begin
      ph = PH_FAIL;
    end
  endfunction

  // Advance the local parser by one accepted byte; 1 when a result is due.
  function automatic bit parse_byte(logic [7:0] c, logic last, output time_fields_t r);
    bit again;
    r = '0;
    if (!text_over) begin
      if (c == 8'd0) begin
        text_over = 1;
        end_text();
      end else begin
        again = 1;
        for (int i = 0; i < 3 && again; i++) again = take_text(c);
      end
    end
    if (!last) return 0;
    end_text();
    if (ph == PH_SEARCH) begin
      r.status = ST_NO_PREFIX;
    end else if (ph != PH_DONE) begin
      r.status = ST_MISMATCH;
    end else begin
      r.status = ST_OK;
      r.weekday = 3'd1;
      for (int i = 6; i >= 0; i--)
        if (wd_word == DAY_LIST[168 - 24 * (i + 1) +: 24]) r.weekday = 3'(i + 1);
      for (int i = 11; i >= 0; i--)
        if (mo_word == MON_LIST[288 - 24 * (i + 1) +: 24]) r.month = 4'(i + 1);
      r.day = held[0];
      r.hour = held[1];
      r.minute = held[2];
      r.second = held[3];
      r.year = acc[15:0];
    end
    clear_parser();
    return 1;
  endfunction

  // ---------------------------------------------------------------- text builder

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  function automatic void put_blank(int lo);
    repeat ($urandom_range(2, lo)) begin
      if ($urandom_range(99) < 80) txt.push_back(8'h20);
      else txt.push_back(8'($urandom_range(13, 9)));
    end
  endfunction

  function automatic void put_word(bit is_month);
    int i;
    if ($urandom_range(99) < 80) begin
      if (is_month) begin
        i = $urandom_range(11);
        for (int k = 2; k >= 0; k--) txt.push_back(MON_LIST[288 - 24 * (i + 1) + 8 * k +: 8]);
      end else begin
        i = $urandom_range(6);
        for (int k = 2; k >= 0; k--) txt.push_back(DAY_LIST[168 - 24 * (i + 1) + 8 * k +: 8]);
      end
    end else begin
      repeat ($urandom_range(4, 1)) txt.push_back(8'($urandom_range(255, 33)));
    end
  endfunction

  function automatic void put_num(bit is_year);
    int r;
    r = $urandom_range(99);
    if ($urandom_range(99) < 8) put_str("+");
    else if ($urandom_range(99) < 8) put_str("-");
    if (r < 3) return;
    if (r < 70) begin
      if ($urandom_range(4) == 0) put_str("0");
      if (is_year) put_str($sformatf("%0d", $urandom_range(2100, 1900)));
      else put_str($sformatf("%0d", $urandom_range(99)));
    end else if (r < 90) begin
      put_str($sformatf("%0d", $urandom()));
    end else begin
      repeat ($urandom_range(14, 10)) txt.push_back(8'($urandom_range(57, 48)));
    end
  endfunction

  function automatic void put_junk();
    repeat ($urandom_range(3)) begin
      case ($urandom_range(5))
        0: put_str("+");
        1: put_str("+CIP");
        2: put_str("+CIPSNTPTIME");
        3: put_str("\r\n");
        4: put_str("AT+CIPSNTPTIME?");
        default: txt.push_back(8'($urandom_range(126, 33)));
      endcase
    end
  endfunction

  // Damage one spot: cut the text short, overwrite, drop or insert a byte.
  function automatic void break_text();
    int pos;
    if (txt.size() == 0) return;
    pos = $urandom_range(txt.size() - 1);
    case ($urandom_range(3))
      0: while (txt.size() > pos) void'(txt.pop_back());
      1: txt[pos] = 8'($urandom_range(255, 1));
      2: txt.delete(pos);
      default: txt.insert(pos, 8'($urandom_range(255)));
    endcase
  endfunction

  function automatic void make_response();
    int kind;
    txt.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(24, 1)) txt.push_back(8'($urandom_range(255)));
      return;
    end
    put_junk();
    put_str("+CIPSNTPTIME:");
    put_blank(0);
    put_word(1'b0);
    put_blank(0);
    put_word(1'b1);
    put_blank(0);
    put_num(1'b0);
    put_blank(1);
    put_num(1'b0);
    put_str(":");
    put_num(1'b0);
    put_str(":");
    put_num(1'b0);
    put_blank(1);
    put_num(1'b1);
    if ($urandom_range(99) < 30) put_str("\r\nOK\r\n");
    if (kind < 35) break_text();
    if ($urandom_range(1) == 1) begin
      txt.push_back(8'd0);
      repeat ($urandom_range(3)) txt.push_back(8'($urandom_range(255)));
    end
    if (txt.size() == 0) txt.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void queue_text(bit typed, time_fields_t want);
    text_item_t it;
    foreach (txt[i]) begin
      it.data = txt[i];
      it.last = (i == txt.size() - 1);
      it.typed = typed;
      it.want = want;
      byte_q.push_back(it);
    end
    n_queued += txt.size();
    n_resp++;
  endfunction

  task automatic wait_drain();
    while (n_taken != n_queued || due_times.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int unsigned byte_goal, int unsigned resp_goal);
    int unsigned b0, r0;
    b0 = n_queued;
    r0 = n_resp;
    while (n_queued - b0 < byte_goal || n_resp - r0 < resp_goal) begin
      make_response();
      queue_text(1'b0, '0);
      while (byte_q.size() > 64) @(posedge clk);
    end
  endtask

  task automatic report(string what, int unsigned got, int unsigned want);
    errors++;
    if (errors <= 40)
      $display("%0t: result %0d %s: got %0d, expected %0d", $realtime, n_results, what,
               got, want);
  endtask

  // ---------------------------------------------------------------- drivers

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        cur <= byte_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_req;
      hold_req = 0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    time_fields_t guess, want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n_taken++;
        if (parse_byte(in_data_byte, in_last_byte, guess))
          due_times.push_back(cur.typed ? cur.want : guess);
      end
      if (out_valid && !out_stall) begin
        n_results++;
        case (out_status)
          ST_OK:        n_ok++;
          ST_NO_PREFIX: n_notag++;
          default:      n_bad++;
        endcase
        if (due_times.size() == 0) begin
          report("arrived with nothing expected", out_status, 0);
        end else begin
          want = due_times.pop_front();
          if (out_status != want.status) report("status", out_status, want.status);
          if (out_weekday != want.weekday) report("weekday", out_weekday, want.weekday);
          if (out_month != want.month) report("month", out_month, want.month);
          if (out_day != want.day) report("day", out_day, want.day);
          if (out_hour != want.hour) report("hour", out_hour, want.hour);
          if (out_minute != want.minute) report("minute", out_minute, want.minute);
          if (out_second != want.second) report("second", out_second, want.second);
          if (out_year != want.year) report("year", out_year, want.year);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("no item moved for %0d cycles", QUIET_LIMIT);
      $display("sntp_time_line_parser test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      txt.delete();
      put_str(script[i].text);
      if (script[i].nul) begin
        txt.push_back(8'd0);
        put_str(script[i].tail);
      end
      queue_text(script[i].typed, script[i].want);
    end
    wait_drain();

    // hold the output while short responses pile up behind it
    hold_req = 80;
    repeat (12) begin
      txt.delete();
      txt.push_back(8'($urandom_range(255, 1)));
      queue_text(1'b0, '0);
    end
    repeat (3) begin
      make_response();
      queue_text(1'b0, '0);
    end
    wait_drain();

    run_random(90, 2);
    wait_drain();
    send_idle = 70;
    recv_stall = 8;
    run_random(90, 2);
    wait_drain();
    send_idle = 0;
    recv_stall = 0;
    run_random(90, 2);
    wait_drain();
    repeat (5) @(posedge clk);

    if (due_times.size() != 0) report("results never arrived", due_times.size(), 0);
    $display("%0d responses in %0d bytes: %0d parsed, %0d without tag, %0d malformed",
             n_resp, n_taken, n_ok, n_notag, n_bad);
    $display("ran sender-heavy, receiver-heavy and no idling, plus one long output hold");
    if (errors == 0) begin
      $display("sntp_time_line_parser test passed");
    end else begin
      $display("sntp_time_line_parser test failed");
    end
    $finish;
  end

endmodule

/* sntp_time_line_parser.f */
rtl/stlp_pkg.sv
rtl/sntp_time_line_parser.sv
sim/sntp_time_line_parser_tb.sv
